// File: hw/rtl/btac_pkg.sv
package btac_pkg;

  localparam int MAX_CANVAS_WIDTH  = 256;
  localparam int MAX_CANVAS_HEIGHT = 256;
  localparam int STORE_DEPTH       = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
  localparam int ADDR_W            = $clog2(STORE_DEPTH);
  localparam int WORD_W            = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STROKE_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd6;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PAINT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] texel_opacity;
    logic [7:0] texel_height;
    logic [7:0] load_red;
    logic [7:0] load_green;
    logic [7:0] load_blue;
    logic [7:0] load_height;
  } btac_in_t;

  typedef struct packed {
    logic       in_bounds;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_height;
  } btac_out_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic read;
    logic mix;
    logic commit;
  } btac_cmd_t;

  typedef struct packed {
    logic out_free;
  } btac_status_t;

  function automatic logic [7:0] scale_sat(input logic [15:0] gain, input logic [7:0] texel);
    logic [23:0] prod;
    logic [15:0] shifted;
    prod    = gain * texel;
    shifted = prod[23:8];
    return (shifted > 16'd255) ? 8'd255 : shifted[7:0];
  endfunction

  function automatic logic [16:0] blend_sum(input logic [7:0] dst, input logic [7:0] src,
                                            input logic [7:0] alpha);
    logic [15:0] a;
    logic [15:0] b;
    a = dst * (8'd255 - alpha);
    b = src * alpha;
    return {1'b0, a} + {1'b0, b} + 17'd127;
  endfunction

  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [17:0] t;
    t = {1'b0, x} + {9'd0, x[16:8]} + 18'd1;
    return (t[17:8] > 10'd255) ? 8'd255 : t[15:8];
  endfunction

endpackage

// File: hw/rtl/btac_ram.sv
module btac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/btac_ctrl.sv
module btac_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  btac_pkg::btac_status_t status,
  output btac_pkg::btac_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_READ = 5'b00100,
    ST_MIX  = 5'b01000,
    ST_DONE = 5'b10000
  } btac_state_t;

  btac_state_t state_r;
  btac_state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/btac_datapath.sv
module btac_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  btac_pkg::btac_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output btac_pkg::btac_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [btac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  btac_pkg::btac_cmd_t               cmd,
  output btac_pkg::btac_status_t            status
);

  localparam logic [12:0] MAX_W13 = 13'(btac_pkg::MAX_CANVAS_WIDTH);
  localparam logic [12:0] MAX_H13 = 13'(btac_pkg::MAX_CANVAS_HEIGHT);

  logic [23:0] stroke_color_r;
  logic [15:0] opacity_gain_r;
  logic [15:0] height_gain_r;
  logic [11:0] row_offset_r;
  logic [11:0] col_offset_r;
  logic [8:0]  canvas_width_r;
  logic [8:0]  canvas_height_r;

  btac_pkg::btac_in_t  item_r;
  logic [7:0]          op_r;
  logic [7:0]          ht_r;
  logic                ok_r;
  logic [btac_pkg::ADDR_W-1:0] addr_r;
  logic [btac_pkg::WORD_W-1:0] old_r;
  logic [16:0]         n_red_r;
  logic [16:0]         n_green_r;
  logic [16:0]         n_blue_r;
  logic [16:0]         n_height_r;

  logic                out_valid_r;
  logic                out_valid_nxt;
  btac_pkg::btac_out_t out_data_r;

  logic [12:0] crow;
  logic [12:0] ccol;
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic        req_known;
  logic        ok_calc;
  logic [btac_pkg::ADDR_W-1:0] addr_calc;
  logic [31:0] addr_wide;

  logic [btac_pkg::WORD_W-1:0] ram_rdata;
  logic [btac_pkg::WORD_W-1:0] paint_word;
  logic [btac_pkg::WORD_W-1:0] load_word;
  logic [btac_pkg::WORD_W-1:0] new_word;
  logic                        ram_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_color_r  <= 24'd0;
      opacity_gain_r  <= 16'd256;
      height_gain_r   <= 16'd256;
      row_offset_r    <= 12'd0;
      col_offset_r    <= 12'd0;
      canvas_width_r  <= 9'd256;
      canvas_height_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        btac_pkg::CFG_STROKE_COLOR:  stroke_color_r  <= cfg_wdata;
        btac_pkg::CFG_OPACITY_GAIN:  opacity_gain_r  <= cfg_wdata[15:0];
        btac_pkg::CFG_HEIGHT_GAIN:   height_gain_r   <= cfg_wdata[15:0];
        btac_pkg::CFG_ROW_OFFSET:    row_offset_r    <= cfg_wdata[11:0];
        btac_pkg::CFG_COL_OFFSET:    col_offset_r    <= cfg_wdata[11:0];
        btac_pkg::CFG_CANVAS_WIDTH:  canvas_width_r  <= cfg_wdata[8:0];
        btac_pkg::CFG_CANVAS_HEIGHT: canvas_height_r <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (item_r.req_type == btac_pkg::REQ_PAINT) begin
      crow = {row_offset_r[11], row_offset_r} + {3'd0, item_r.row};
      ccol = {col_offset_r[11], col_offset_r} + {3'd0, item_r.col};
    end else begin
      crow = {3'd0, item_r.row};
      ccol = {3'd0, item_r.col};
    end
    w_eff = ({4'd0, canvas_width_r} > MAX_W13) ? MAX_W13 : {4'd0, canvas_width_r};
    h_eff = ({4'd0, canvas_height_r} > MAX_H13) ? MAX_H13 : {4'd0, canvas_height_r};
    req_known = (item_r.req_type == btac_pkg::REQ_LOAD) ||
                (item_r.req_type == btac_pkg::REQ_PAINT) ||
                (item_r.req_type == btac_pkg::REQ_READ);
    ok_calc = req_known && !crow[12] && !ccol[12] && (crow < h_eff) && (ccol < w_eff);
    addr_wide = 32'(crow[11:0]) * 32'(btac_pkg::MAX_CANVAS_WIDTH) + 32'(ccol[11:0]);
    addr_calc = addr_wide[btac_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.calc) begin
      ok_r   <= ok_calc;
      addr_r <= addr_calc;
      op_r   <= btac_pkg::scale_sat(opacity_gain_r, item_r.texel_opacity);
      ht_r   <= btac_pkg::scale_sat(height_gain_r, item_r.texel_height);
    end
    if (cmd.mix) begin
      old_r      <= ram_rdata;
      n_red_r    <= btac_pkg::blend_sum(ram_rdata[31:24], stroke_color_r[23:16], op_r);
      n_green_r  <= btac_pkg::blend_sum(ram_rdata[23:16], stroke_color_r[15:8], op_r);
      n_blue_r   <= btac_pkg::blend_sum(ram_rdata[15:8], stroke_color_r[7:0], op_r);
      n_height_r <= btac_pkg::blend_sum(ram_rdata[7:0], ht_r, ht_r);
    end
  end

  always_comb begin
    paint_word = {btac_pkg::div255(n_red_r), btac_pkg::div255(n_green_r),
                  btac_pkg::div255(n_blue_r), btac_pkg::div255(n_height_r)};
    load_word  = {item_r.load_red, item_r.load_green, item_r.load_blue, item_r.load_height};
    case (item_r.req_type)
      btac_pkg::REQ_LOAD:  new_word = load_word;
      btac_pkg::REQ_PAINT: new_word = paint_word;
      btac_pkg::REQ_READ:  new_word = old_r;
      default:             new_word = '0;
    endcase
    if (!ok_r) begin
      new_word = '0;
    end
    ram_we = cmd.commit && ok_r &&
             ((item_r.req_type == btac_pkg::REQ_LOAD) || (item_r.req_type == btac_pkg::REQ_PAINT));
  end

  btac_ram #(
    .WIDTH (btac_pkg::WORD_W),
    .DEPTH (btac_pkg::STORE_DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (new_word),
    .re    (cmd.read),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.in_bounds    <= ok_r;
      out_data_r.pixel_red    <= new_word[31:24];
      out_data_r.pixel_green  <= new_word[23:16];
      out_data_r.pixel_blue   <= new_word[15:8];
      out_data_r.pixel_height <= new_word[7:0];
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// File: hw/rtl/brush_texel_alpha_compositor_unit.sv
// Channel  Direction  Signals                       Payload
// in       input      in_valid, in_stall            btac_in_t
// out      output     out_valid, out_stall          btac_out_t
// cfg      input      cfg_we, cfg_index, cfg_wdata  register write
//
// Each request passes through five steps: accept, address and gain scaling, canvas read, blend
// products, then write-back with the result load. A new request is accepted only after the
// previous one has left its last step.
// Reset clears the controller, the output valid and the configuration registers; canvas contents
// are undefined until loaded and get no clearing pass.
// A stalled result holds in the output register; the next request is accepted
// meanwhile and waits in its last step until that beat is taken.
module brush_texel_alpha_compositor_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  btac_pkg::btac_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output btac_pkg::btac_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [btac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btac_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  btac_pkg::btac_cmd_t    cmd;
  btac_pkg::btac_status_t status;

  btac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  btac_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: test/canvas_check_pkg.sv
`timescale 1ns / 100ps
package canvas_check_pkg;
  import btac_pkg::*;

  class canvas_shadow;
    logic [23:0]        stroke_rgb;
    logic [15:0]        opacity_gain;
    logic [15:0]        height_gain;
    logic signed [11:0] row_shift;
    logic signed [11:0] col_shift;
    logic [8:0]         cols_used;
    logic [8:0]         rows_used;
    bit [31:0]          pixels [STORE_DEPTH];
    bit                 loaded [STORE_DEPTH];
    int unsigned        loaded_addrs [$];
    btac_out_t          pixels_due [$];
    int                 mismatch_count;

    function new();
      stroke_rgb = '0;
      opacity_gain = 16'd256;
      height_gain = 16'd256;
      row_shift = '0;
      col_shift = '0;
      cols_used = 9'd256;
      rows_used = 9'd256;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STROKE_COLOR:  stroke_rgb = value;
        CFG_OPACITY_GAIN:  opacity_gain = value[15:0];
        CFG_HEIGHT_GAIN:   height_gain = value[15:0];
        CFG_ROW_OFFSET:    row_shift = value[11:0];
        CFG_COL_OFFSET:    col_shift = value[11:0];
        CFG_CANVAS_WIDTH:  cols_used = value[8:0];
        CFG_CANVAS_HEIGHT: rows_used = value[8:0];
        default: ;
      endcase
    endfunction

    function int cols_limit();
      return (cols_used > MAX_CANVAS_WIDTH) ? MAX_CANVAS_WIDTH : int'(cols_used);
    endfunction

    function int rows_limit();
      return (rows_used > MAX_CANVAS_HEIGHT) ? MAX_CANVAS_HEIGHT : int'(rows_used);
    endfunction

    // Finds the canvas word a request touches; paint positions are shifted by the
    // stroke offsets first. Returns 0 when the pixel lies off the canvas in use or the request type is unknown.
    function bit target(btac_in_t q, output int unsigned addr);
      int r;
      int c;
      r = int'(q.row);
      c = int'(q.col);
      addr = 0;
      if (q.req_type == REQ_PAINT) begin
        r += int'(row_shift);
        c += int'(col_shift);
      end else if (q.req_type != REQ_LOAD && q.req_type != REQ_READ) begin
        return 0;
      end
      if (r < 0 || c < 0 || r >= rows_limit() || c >= cols_limit()) return 0;
      addr = r * MAX_CANVAS_WIDTH + c;
      return 1;
    endfunction

    function logic [7:0] scaled(logic [15:0] gain, logic [7:0] texel);
      int unsigned p;
      p = (int'(gain) * int'(texel)) >> 8;
      return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    function logic [7:0] mix(logic [7:0] dst, logic [7:0] src, logic [7:0] alpha);
      int unsigned n;
      n = (int'(dst) * (255 - int'(alpha)) + int'(src) * int'(alpha) + 127) / 255;
      return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function void note_request(btac_in_t q);
      btac_out_t   res;
      int unsigned addr;
      logic [31:0] word;
      logic [7:0]  op;
      logic [7:0]  ht;
      res = '0;
      word = '0;
      res.in_bounds = target(q, addr);
      if (res.in_bounds) begin
        case (q.req_type)
          REQ_LOAD: begin
            word = {q.load_red, q.load_green, q.load_blue, q.load_height};
            if (!loaded[addr]) loaded_addrs.push_back(addr);
            loaded[addr] = 1'b1;
            pixels[addr] = word;
          end
          REQ_PAINT: begin
            op = scaled(opacity_gain, q.texel_opacity);
            ht = scaled(height_gain, q.texel_height);
            word = pixels[addr];
            word = {mix(word[31:24], stroke_rgb[23:16], op),
                    mix(word[23:16], stroke_rgb[15:8], op),
                    mix(word[15:8], stroke_rgb[7:0], op),
                    mix(word[7:0], ht, ht)};
            pixels[addr] = word;
          end
          default: word = pixels[addr];
        endcase
      end
      {res.pixel_red, res.pixel_green, res.pixel_blue, res.pixel_height} = word;
      pixels_due.push_back(res);
    endfunction

    task report(string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_pixel(btac_out_t got);
      btac_out_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("result beat %h with no request pending", got));
        return;
      end
      want = pixels_due.pop_front();
      if (got.in_bounds !== want.in_bounds)
        report($sformatf("in_bounds %b, expected %b", got.in_bounds, want.in_bounds));
      if (got.pixel_red !== want.pixel_red)
        report($sformatf("pixel_red %h, expected %h", got.pixel_red, want.pixel_red));
      if (got.pixel_green !== want.pixel_green)
        report($sformatf("pixel_green %h, expected %h", got.pixel_green, want.pixel_green));
      if (got.pixel_blue !== want.pixel_blue)
        report($sformatf("pixel_blue %h, expected %h", got.pixel_blue, want.pixel_blue));
      if (got.pixel_height !== want.pixel_height)
        report($sformatf("pixel_height %h, expected %h", got.pixel_height, want.pixel_height));
    endtask

    task close_out();
      foreach (pixels_due[i]) report($sformatf("result %h never arrived", pixels_due[i]));
      pixels_due.delete();
    endtask
  endclass

endpackage

// File: test/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import btac_pkg::*;
  import canvas_check_pkg::*;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 210;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 64;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  btac_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  btac_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit                    quiet;
  bit                    long_hold;
  canvas_shadow          shadow;

  always #5 clk = ~clk;

  brush_texel_alpha_compositor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) shadow.note_request(in_data);
      if (out_valid && !out_stall) shadow.check_pixel(out_data);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    shadow.set_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (shadow.pixels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send(btac_in_t q);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = q;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // A read or paint that would land on a pixel never loaded becomes a load of it.
  function automatic btac_in_t guard_unloaded(btac_in_t q);
    int unsigned addr;
    if ((q.req_type == REQ_PAINT || q.req_type == REQ_READ) && shadow.target(q, addr) &&
        !shadow.loaded[addr]) begin
      q.req_type = REQ_LOAD;
      q.row = 10'(addr / MAX_CANVAS_WIDTH);
      q.col = 10'(addr % MAX_CANVAS_WIDTH);
    end
    return q;
  endfunction

  function automatic btac_in_t request_of(logic [1:0] kind, int row, int col,
                                          int v0, int v1, int v2, int v3);
    btac_in_t q;
    q.req_type = kind;
    q.row = 10'(row);
    q.col = 10'(col);
    q.texel_opacity = 8'(v0);
    q.texel_height = 8'(v1);
    q.load_red = 8'(v0);
    q.load_green = 8'(v1);
    q.load_blue = 8'(v2);
    q.load_height = 8'(v3);
    return q;
  endfunction

  function automatic btac_in_t random_request();
    btac_in_t    q;
    int          pick;
    int          r;
    int          c;
    int          tries;
    int unsigned addr;
    pick = $urandom_range(0, 99);
    q.req_type = (pick < 30) ? REQ_LOAD : (pick < 75) ? REQ_PAINT :
                 (pick < 95) ? REQ_READ : REQ_UNUSED;
    q.row = 10'($urandom);
    q.col = 10'($urandom);
    q.texel_opacity = 8'($urandom);
    q.texel_height = 8'($urandom);
    q.load_red = 8'($urandom);
    q.load_green = 8'($urandom);
    q.load_blue = 8'($urandom);
    q.load_height = 8'($urandom);
    if (q.req_type != REQ_UNUSED && shadow.rows_limit() > 0 && shadow.cols_limit() > 0 &&
        $urandom_range(0, 7) != 0) begin
      r = $urandom_range(0, shadow.rows_limit() - 1);
      c = $urandom_range(0, shadow.cols_limit() - 1);
      if (q.req_type != REQ_LOAD && shadow.loaded_addrs.size() != 0) begin
        for (tries = 0; tries < 4; tries++) begin
          addr = shadow.loaded_addrs[$urandom_range(0, shadow.loaded_addrs.size() - 1)];
          if (addr / MAX_CANVAS_WIDTH < shadow.rows_limit() &&
              addr % MAX_CANVAS_WIDTH < shadow.cols_limit()) begin
            r = addr / MAX_CANVAS_WIDTH;
            c = addr % MAX_CANVAS_WIDTH;
            break;
          end
        end
      end
      if (q.req_type == REQ_PAINT) begin
        r -= int'(shadow.row_shift);
        c -= int'(shadow.col_shift);
      end
      if (r >= 0 && r < 1024) q.row = 10'(r);
      if (c >= 0 && c < 1024) q.col = 10'(c);
    end
    return guard_unloaded(q);
  endfunction

  task automatic configure_stroke(int phase);
    logic [23:0] color;
    logic [15:0] og;
    logic [15:0] hg;
    int          ro;
    int          co;
    int          w;
    int          h;
    color = 24'($urandom);
    og = 16'($urandom);
    hg = 16'($urandom);
    ro = int'($urandom_range(0, 20)) - 10;
    co = int'($urandom_range(0, 20)) - 10;
    w = 12;
    h = 12;
    case (phase)
      0: begin
        color = 24'hFFFFFF;
        og = 16'hFFFF;
        hg = 16'hFFFF;
        ro = 0;
        co = 0;
        w = 8;
        h = 8;
      end
      1: begin
        color = 24'h000000;
        og = 16'd0;
        hg = 16'd0;
        ro = -3;
        co = 5;
        w = 16;
        h = 4;
      end
      2: begin
        og = 16'd256;
        hg = 16'd256;
        ro = 2047;
        co = -2048;
        w = 256;
        h = 256;
      end
      3: begin
        ro = -2048;
        co = 2047;
        w = 1;
        h = 1;
      end
      4: begin
        og = 16'($urandom_range(128, 1024));
        hg = 16'($urandom_range(128, 1024));
        ro = 0;
        co = 0;
        w = 0;
        h = 12;
      end
      5: begin
        ro = 100;
        co = 200;
        w = 300;
        h = 511;
      end
      6: begin
        og = 16'($urandom_range(0, 2048));
        hg = 16'($urandom_range(0, 2048));
      end
      default: begin
        ro = int'($urandom_range(0, 4)) - 2;
        co = int'($urandom_range(0, 4)) - 2;
        w = 6;
        h = 6;
      end
    endcase
    write_reg(CFG_STROKE_COLOR, color);
    write_reg(CFG_OPACITY_GAIN, {8'd0, og});
    write_reg(CFG_HEIGHT_GAIN, {8'd0, hg});
    write_reg(CFG_ROW_OFFSET, {12'd0, 12'(ro)});
    write_reg(CFG_COL_OFFSET, {12'd0, 12'(co)});
    write_reg(CFG_CANVAS_WIDTH, {15'd0, 9'(w)});
    write_reg(CFG_CANVAS_HEIGHT, {15'd0, 9'(h)});
  endtask

  // Result-side stall: random bursts, one long hold-off on request, none at the end.
  initial begin
    int held;
    out_stall = 1'b0;
    forever begin
      if (long_hold) begin
        out_stall = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        @(negedge clk);
      end
    end
  end

  initial begin
    btac_in_t warmup [$];
    int       phase;
    shadow = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    warmup = '{
      request_of(REQ_LOAD, 0, 0, 0, 0, 0, 0),
      request_of(REQ_LOAD, 255, 255, 255, 255, 255, 255),
      request_of(REQ_LOAD, 0, 255, 255, 0, 128, 1),
      request_of(REQ_LOAD, 255, 0, 1, 2, 3, 254),
      request_of(REQ_READ, 0, 0, 0, 0, 0, 0),
      request_of(REQ_READ, 255, 255, 0, 0, 0, 0),
      request_of(REQ_READ, 0, 255, 0, 0, 0, 0),
      request_of(REQ_READ, 255, 0, 0, 0, 0, 0),
      request_of(REQ_LOAD, 256, 0, 9, 9, 9, 9),
      request_of(REQ_LOAD, 0, 256, 9, 9, 9, 9),
      request_of(REQ_LOAD, 1023, 1023, 255, 255, 255, 255),
      request_of(REQ_READ, 1023, 1023, 0, 0, 0, 0),
      request_of(REQ_READ, 256, 255, 0, 0, 0, 0),
      request_of(REQ_PAINT, 0, 0, 255, 255, 0, 0),
      request_of(REQ_PAINT, 0, 0, 0, 0, 0, 0),
      request_of(REQ_PAINT, 255, 255, 128, 77, 0, 0),
      request_of(REQ_PAINT, 0, 255, 1, 254, 0, 0),
      request_of(REQ_PAINT, 1023, 0, 255, 255, 0, 0),
      request_of(REQ_UNUSED, 1023, 1023, 255, 255, 255, 255),
      request_of(REQ_UNUSED, 0, 0, 0, 0, 0, 0),
      request_of(REQ_READ, 0, 0, 0, 0, 0, 0),
      request_of(REQ_READ, 255, 255, 0, 0, 0, 0)
    };
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    foreach (warmup[i]) send(guard_unloaded(warmup[i]));
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      configure_stroke(phase);
      quiet = (phase == PHASES - 1);
      long_hold = (phase == 6);
      repeat (PHASE_ITEMS) send(random_request());
    end
    settle();
    shadow.close_out();
    if (shadow.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
